// ===== design/worsp_pkg.sv =====
// shared types and constants for the window occlusion region splitter
// no dependencies; used by worsp_split, the core and the bench
package worsp_pkg;

    localparam int DEF_MAX_REGIONS = 512;
    localparam int DEF_COORD_BITS  = 12;
    localparam int DEF_OWNER_BITS  = 8;

    typedef enum logic [1:0] {
        FUNC_CLEAR = 2'd0,
        FUNC_ADD   = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_NOP   = 2'd3
    } func_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [10:0] win_x;
        logic [10:0] win_y;
        logic [10:0] win_w;
        logic [10:0] win_h;
        logic [7:0]  window_id;
        logic [8:0]  region_index;
    } in_t;

    typedef struct packed {
        logic [11:0] reg_x;
        logic [11:0] reg_y;
        logic [11:0] reg_w;
        logic [11:0] reg_h;
        logic [7:0]  reg_owner;
        logic [9:0]  region_count;
        logic        index_valid;
        logic        overflow;
    } out_t;

    // classification of one stored rectangle against the window
    typedef struct packed {
        logic overlap;
        logic top;
        logic bottom;
        logic left;
        logic right;
    } split_flags_t;

endpackage

// ===== design/worsp_ram.sv =====
// simple dual-port region memory, one write and one registered read per cycle
// no dependencies
module worsp_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 56
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/worsp_split.sv =====
// overlap test and piece geometry for one stored rectangle against the window
// depends on worsp_pkg
module worsp_split #(
    parameter int COORD_BITS = 12
) (
    input  logic [COORD_BITS-1:0]   rx,
    input  logic [COORD_BITS-1:0]   ry,
    input  logic [COORD_BITS-1:0]   rw,
    input  logic [COORD_BITS-1:0]   rh,
    input  logic [COORD_BITS-1:0]   wx,
    input  logic [COORD_BITS-1:0]   wy,
    input  logic [COORD_BITS-1:0]   ww,
    input  logic [COORD_BITS-1:0]   wh,
    input  logic [1:0]              sub,
    output worsp_pkg::split_flags_t flags,
    output logic [COORD_BITS-1:0]   px,
    output logic [COORD_BITS-1:0]   py,
    output logic [COORD_BITS-1:0]   pw,
    output logic [COORD_BITS-1:0]   ph
);
    import worsp_pkg::*;

    localparam int E = COORD_BITS + 1;

    logic [E-1:0] ex, ey, ex2, ey2, ewx, ewy, ewx2, ewy2, band_y, band_y2;

    always_comb begin
        ex   = {1'b0, rx};
        ey   = {1'b0, ry};
        ex2  = {1'b0, rx} + {1'b0, rw};
        ey2  = {1'b0, ry} + {1'b0, rh};
        ewx  = {1'b0, wx};
        ewy  = {1'b0, wy};
        ewx2 = {1'b0, wx} + {1'b0, ww};
        ewy2 = {1'b0, wy} + {1'b0, wh};

        flags.overlap = !(ewx >= ex2 || ewy >= ey2 || ewx2 <= ex || ewy2 <= ey);
        flags.top     = (ewy > ey) && (ewy < ey2);
        flags.bottom  = (ewy2 > ey) && (ewy2 < ey2);
        flags.left    = (ewx > ex) && (ewx < ex2);
        flags.right   = (ewx2 < ex2) && (ewx2 > ex);

        // rows left over between the top and bottom pieces
        band_y  = flags.top ? ewy : ey;
        band_y2 = flags.bottom ? ewy2 : ey2;

        case (sub)
            2'd0: begin
                px = rx; py = ry; pw = rw;
                ph = COORD_BITS'(ewy - ey);
            end
            2'd1: begin
                px = rx; py = COORD_BITS'(ewy2); pw = rw;
                ph = COORD_BITS'(ey2 - ewy2);
            end
            2'd2: begin
                px = rx; py = COORD_BITS'(band_y);
                pw = COORD_BITS'(ewx - ex);
                ph = COORD_BITS'(band_y2 - band_y);
            end
            default: begin
                px = COORD_BITS'(ewx2); py = COORD_BITS'(band_y);
                pw = COORD_BITS'(ex2 - ewx2);
                ph = COORD_BITS'(band_y2 - band_y);
            end
        endcase
    end

endmodule

// ===== design/window_occlusion_region_splitter_core.sv =====
// top level of the window occlusion region splitter: control sequencer
// depends on worsp_pkg, worsp_ram and worsp_split
//
// usage
//   s_ channel takes one command transaction: clear table, add window on top,
//   read region entry, or no operation. m_ channel returns exactly one result
//   transaction per command with the entry read (zeros otherwise), the live
//   region count and the sticky overflow flag.
// command flow
//   one command at a time; s_ready is high only while the sequencer is idle
//   clear, read, no-op: from idle through the finish state to the output register
//   add: counting pass, limit step, split pass, window write, finish state; its
//   length grows with the number of live regions, set by the single read port
//   of the region memory: a counting pass reads each region once, then a split
//   pass reads it again and steps through its four possible pieces, writing the
//   kept pieces and survivors into the other bank
// reset
//   aresetn clears the count, overflow flag, bank select and output valid;
//   the memory itself is not cleared and needs no clearing pass
// stalls
//   the result sits in an output register; if m_ready is low the sequencer
//   waits before loading the next result, so no result is lost
module window_occlusion_region_splitter_core #(
    parameter int MAX_REGIONS = worsp_pkg::DEF_MAX_REGIONS,
    parameter int COORD_BITS  = worsp_pkg::DEF_COORD_BITS,
    parameter int OWNER_BITS  = worsp_pkg::DEF_OWNER_BITS
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  worsp_pkg::in_t   s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output worsp_pkg::out_t  m_data
);
    import worsp_pkg::*;

    localparam int AW    = $clog2(MAX_REGIONS);
    localparam int CNT_W = $clog2(MAX_REGIONS + 1);
    localparam int PC_W  = CNT_W + 2;
    localparam int WORD  = 4 * COORD_BITS + OWNER_BITS;
    localparam logic [PC_W-1:0] LIMIT = PC_W'(MAX_REGIONS - 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_CNT_RD, ST_CNT_EV, ST_LIMIT, ST_SPL_RD, ST_SPL_CAP,
        ST_SPL_SUB, ST_WIN, ST_FIN
    } state_t;

    state_t                state_reg;
    logic [1:0]            func_reg;
    logic                  idx_ok_reg;
    logic [COORD_BITS-1:0] wx_reg, wy_reg, ww_reg, wh_reg;
    logic [OWNER_BITS-1:0] id_reg;
    logic [CNT_W-1:0]      live_reg, idx_reg, surv_reg, nsurv_reg, kept_reg, s_cnt_reg;
    logic [PC_W-1:0]       pc_reg, p_cnt_reg;
    logic [1:0]            sub_reg;
    logic                  bank_reg, ovf_reg;
    logic [WORD-1:0]       rect_reg;
    logic                  m_valid_reg;
    out_t                  m_data_reg;
    out_t                  m_data_next;

    // memory port signals
    logic             mem_we, mem_re;
    logic [AW:0]      mem_waddr, mem_raddr;
    logic [WORD-1:0]  mem_wdata, mem_rdata;

    // split unit signals
    logic [WORD-1:0]       cur_rect;
    split_flags_t          flags;
    logic [COORD_BITS-1:0] px, py, pw, ph;
    logic [PC_W-1:0]       piece_n;
    logic                  piece_on;

    // command accept, capacity check and write positions
    logic                  accept;
    logic [PC_W-1:0]       nsurv_w, room_w, kept_w;
    logic [CNT_W-1:0]      piece_pos, surv_pos;

    worsp_ram #(
        .DEPTH(2 * (1 << AW)),
        .WIDTH(WORD)
    ) u_ram (
        .aclk (aclk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .re   (mem_re),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    // entry layout is {x, y, w, h, owner}
    assign cur_rect = (state_reg == ST_CNT_EV) ? mem_rdata : rect_reg;

    worsp_split #(
        .COORD_BITS(COORD_BITS)
    ) u_split (
        .rx   (cur_rect[WORD-1 -: COORD_BITS]),
        .ry   (cur_rect[WORD-1-COORD_BITS -: COORD_BITS]),
        .rw   (cur_rect[WORD-1-2*COORD_BITS -: COORD_BITS]),
        .rh   (cur_rect[WORD-1-3*COORD_BITS -: COORD_BITS]),
        .wx   (wx_reg),
        .wy   (wy_reg),
        .ww   (ww_reg),
        .wh   (wh_reg),
        .sub  (sub_reg),
        .flags(flags),
        .px   (px),
        .py   (py),
        .pw   (pw),
        .ph   (ph)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // number of pieces this region splits into
    assign piece_n = flags.overlap
        ? PC_W'({1'b0, flags.top} + {1'b0, flags.bottom}) +
          PC_W'({1'b0, flags.left} + {1'b0, flags.right})
        : '0;

    // which piece the sub step looks at, in creation order top/bottom/left/right
    always_comb begin
        case (sub_reg)
            2'd0:    piece_on = flags.top;
            2'd1:    piece_on = flags.bottom;
            2'd2:    piece_on = flags.left;
            default: piece_on = flags.right;
        endcase
    end

    // capacity check: survivors first, then pieces in creation order
    assign nsurv_w = (PC_W'(surv_reg) > LIMIT) ? LIMIT : PC_W'(surv_reg);
    assign room_w  = LIMIT - nsurv_w;
    assign kept_w  = (pc_reg < room_w) ? pc_reg : room_w;

    // pieces land in reverse order right after the window, survivors after them
    assign piece_pos = kept_reg - CNT_W'(p_cnt_reg);
    assign surv_pos  = kept_reg + s_cnt_reg + CNT_W'(1);

    // result transaction built from the count, the flag and the entry read
    always_comb begin
        m_data_next              = '0;
        m_data_next.region_count = 10'(live_reg);
        m_data_next.overflow     = ovf_reg;
        if ((func_t'(func_reg) == FUNC_READ) && idx_ok_reg) begin
            m_data_next.reg_x       = 12'(mem_rdata[WORD-1 -: COORD_BITS]);
            m_data_next.reg_y       = 12'(mem_rdata[WORD-1-COORD_BITS -: COORD_BITS]);
            m_data_next.reg_w       = 12'(mem_rdata[WORD-1-2*COORD_BITS -: COORD_BITS]);
            m_data_next.reg_h       = 12'(mem_rdata[WORD-1-3*COORD_BITS -: COORD_BITS]);
            m_data_next.reg_owner   = 8'(mem_rdata[OWNER_BITS-1:0]);
            m_data_next.index_valid = 1'b1;
        end
    end

    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = {bank_reg, idx_reg[AW-1:0]};
        mem_we    = 1'b0;
        mem_waddr = {~bank_reg, surv_pos[AW-1:0]};
        mem_wdata = rect_reg;
        unique case (state_reg)
            ST_IDLE: begin
                mem_re    = accept && (func_t'(s_data.func) == FUNC_READ);
                mem_raddr = {bank_reg, AW'(s_data.region_index)};
            end
            ST_CNT_RD, ST_SPL_RD: begin
                mem_re = (idx_reg != live_reg);
            end
            ST_SPL_SUB: begin
                if (!flags.overlap) begin
                    mem_we = (s_cnt_reg < nsurv_reg);
                end else begin
                    mem_we    = piece_on && (p_cnt_reg < PC_W'(kept_reg));
                    mem_waddr = {~bank_reg, piece_pos[AW-1:0]};
                    mem_wdata = {px, py, pw, ph,
                                 rect_reg[OWNER_BITS-1:0]};
                end
            end
            ST_WIN: begin
                mem_we    = 1'b1;
                mem_waddr = {~bank_reg, AW'(0)};
                mem_wdata = {wx_reg, wy_reg, ww_reg, wh_reg, id_reg};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            live_reg    <= '0;
            ovf_reg     <= 1'b0;
            bank_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            // the finish state reloads the output register itself
            if (m_valid_reg && m_ready && (state_reg != ST_FIN)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        func_reg   <= s_data.func;
                        wx_reg     <= COORD_BITS'(s_data.win_x);
                        wy_reg     <= COORD_BITS'(s_data.win_y);
                        ww_reg     <= COORD_BITS'(s_data.win_w);
                        wh_reg     <= COORD_BITS'(s_data.win_h);
                        id_reg     <= OWNER_BITS'(s_data.window_id);
                        idx_ok_reg <= (32'(s_data.region_index) < 32'(live_reg));
                        idx_reg    <= '0;
                        surv_reg   <= '0;
                        pc_reg     <= '0;
                        case (func_t'(s_data.func))
                            FUNC_CLEAR: begin
                                live_reg  <= '0;
                                ovf_reg   <= 1'b0;
                                state_reg <= ST_FIN;
                            end
                            FUNC_ADD: state_reg <= ST_CNT_RD;
                            default:  state_reg <= ST_FIN;
                        endcase
                    end
                end
                // counting pass: survivors and pieces
                ST_CNT_RD: begin
                    state_reg <= (idx_reg == live_reg) ? ST_LIMIT : ST_CNT_EV;
                end
                ST_CNT_EV: begin
                    surv_reg  <= surv_reg + CNT_W'(!flags.overlap);
                    pc_reg    <= pc_reg + piece_n;
                    idx_reg   <= idx_reg + CNT_W'(1);
                    state_reg <= ST_CNT_RD;
                end
                ST_LIMIT: begin
                    nsurv_reg <= CNT_W'(nsurv_w);
                    kept_reg  <= CNT_W'(kept_w);
                    if ((PC_W'(surv_reg) > LIMIT) || (pc_reg > kept_w)) begin
                        ovf_reg <= 1'b1;
                    end
                    idx_reg   <= '0;
                    p_cnt_reg <= '0;
                    s_cnt_reg <= '0;
                    state_reg <= ST_SPL_RD;
                end
                // split pass: write pieces and survivors into the other bank
                ST_SPL_RD: begin
                    state_reg <= (idx_reg == live_reg) ? ST_WIN : ST_SPL_CAP;
                end
                ST_SPL_CAP: begin
                    rect_reg  <= mem_rdata;
                    sub_reg   <= 2'd0;
                    state_reg <= ST_SPL_SUB;
                end
                ST_SPL_SUB: begin
                    if (!flags.overlap) begin
                        s_cnt_reg <= s_cnt_reg + CNT_W'(1);
                        idx_reg   <= idx_reg + CNT_W'(1);
                        state_reg <= ST_SPL_RD;
                    end else begin
                        if (piece_on) begin
                            p_cnt_reg <= p_cnt_reg + PC_W'(1);
                        end
                        if (sub_reg == 2'd3) begin
                            idx_reg   <= idx_reg + CNT_W'(1);
                            state_reg <= ST_SPL_RD;
                        end else begin
                            sub_reg <= sub_reg + 2'd1;
                        end
                    end
                end
                ST_WIN: begin
                    live_reg  <= kept_reg + nsurv_reg + CNT_W'(1);
                    bank_reg  <= ~bank_reg;
                    state_reg <= ST_FIN;
                end
                ST_FIN: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= m_data_next;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // the table never holds more than its capacity
    a_live_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(live_reg) <= MAX_REGIONS)
        else $error("live region count above capacity");

    // an add never writes into the bank that is being read
    a_bank_sep: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (mem_waddr[AW] != bank_reg))
        else $error("write into the active bank");

    // a clear leaves an empty table and a cleared flag
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN && func_t'(func_reg) == FUNC_CLEAR) |->
        (live_reg == '0 && !ovf_reg))
        else $error("clear did not empty the table");

    // the kept pieces and survivors always fit beside the window
    a_fit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SPL_RD) |->
        (32'(kept_reg) + 32'(nsurv_reg) < MAX_REGIONS))
        else $error("split plan exceeds capacity");

endmodule

// ===== bench/tb_window_occlusion_region_splitter_core.sv =====
// self-checking bench for window_occlusion_region_splitter_core
// depends on worsp_pkg and the core; drives commands, predicts each result and checks it
module tb_window_occlusion_region_splitter_core;
    timeunit 1ns;
    timeprecision 1ps;

    import worsp_pkg::*;

    localparam int NREG  = DEF_MAX_REGIONS;
    localparam int CMSK  = (1 << DEF_COORD_BITS) - 1;
    localparam int OMSK  = (1 << DEF_OWNER_BITS) - 1;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    window_occlusion_region_splitter_core i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // shadow copy of the region table
    typedef struct {
        int unsigned x, y, w, h, o;
    } rect_t;

    rect_t       shadow_tbl [NREG];
    rect_t       keep_list  [NREG];
    rect_t       piece_list [NREG];
    int unsigned piece_cnt;
    int unsigned live_regions = 0;
    int unsigned ovf_sticky   = 0;

    out_t        pending_results [$];
    int          error_cnt = 0;
    int unsigned cyc = 0;
    bit          hold_req = 0;

    // quiet stretch: neither side idles during part of every window of cycles
    function automatic bit quiet();
        return (cyc % 20000) < 5000;
    endfunction

    always @(posedge aclk) cyc <= cyc + 1;

    function automatic void push_piece(int unsigned x, int unsigned y, int unsigned w,
                                       int unsigned h, int unsigned o);
        if (piece_cnt < NREG) begin
            piece_list[piece_cnt].x = x & CMSK;
            piece_list[piece_cnt].y = y & CMSK;
            piece_list[piece_cnt].w = w & CMSK;
            piece_list[piece_cnt].h = h & CMSK;
            piece_list[piece_cnt].o = o & OMSK;
        end
        piece_cnt++;
    endfunction

    // occlusion split of every live region by the new window
    function automatic void split_by_window(int unsigned wx, int unsigned wy, int unsigned ww,
                                            int unsigned wh, int unsigned id);
        int unsigned wx2, wy2, nkeep, room, kept, k, rx2, ry2, py, ph;
        rect_t r;
        bit top, bot;
        nkeep = 0;
        wx2 = wx + ww;
        wy2 = wy + wh;
        piece_cnt = 0;
        for (int unsigned i = 0; i < live_regions; i++) begin
            r = shadow_tbl[i];
            rx2 = r.x + r.w;
            ry2 = r.y + r.h;
            top = 0;
            bot = 0;
            // strict test: touching edges do not count
            if (wx >= rx2 || wy >= ry2 || wx2 <= r.x || wy2 <= r.y) begin
                keep_list[nkeep++] = r;
                continue;
            end
            if (wy > r.y && wy < ry2) begin
                push_piece(r.x, r.y, r.w, wy - r.y, r.o);
                top = 1;
            end
            if (wy2 > r.y && wy2 < ry2) begin
                push_piece(r.x, wy2, r.w, ry2 - wy2, r.o);
                bot = 1;
            end
            py = top ? wy : r.y;
            ph = (bot ? wy2 : ry2) - py;
            if (wx > r.x && wx < rx2) push_piece(r.x, py, wx - r.x, ph, r.o);
            if (wx2 < rx2 && wx2 > r.x) push_piece(wx2, py, rx2 - wx2, ph, r.o);
        end
        // table full: survivors trimmed first, then late pieces dropped
        if (nkeep > NREG - 1) begin
            nkeep = NREG - 1;
            ovf_sticky = 1;
        end
        room = NREG - 1 - nkeep;
        kept = (piece_cnt < room) ? piece_cnt : room;
        if (piece_cnt > kept) ovf_sticky = 1;
        shadow_tbl[0] = '{wx, wy, ww, wh, id & OMSK};
        k = 1;
        for (int unsigned j = kept; j > 0; j--) shadow_tbl[k++] = piece_list[j - 1];
        for (int unsigned j = 0; j < nkeep; j++) shadow_tbl[k++] = keep_list[j];
        live_regions = k;
    endfunction

    function automatic out_t region_result(in_t c);
        out_t o;
        o = '0;
        case (func_t'(c.func))
            FUNC_CLEAR: begin
                live_regions = 0;
                ovf_sticky   = 0;
            end
            FUNC_ADD: split_by_window(32'(c.win_x), 32'(c.win_y), 32'(c.win_w),
                                      32'(c.win_h), 32'(c.window_id));
            FUNC_READ: begin
                if (32'(c.region_index) < live_regions) begin
                    o.reg_x       = 12'(shadow_tbl[c.region_index].x);
                    o.reg_y       = 12'(shadow_tbl[c.region_index].y);
                    o.reg_w       = 12'(shadow_tbl[c.region_index].w);
                    o.reg_h       = 12'(shadow_tbl[c.region_index].h);
                    o.reg_owner   = 8'(shadow_tbl[c.region_index].o);
                    o.index_valid = 1'b1;
                end
            end
            default: ;
        endcase
        o.region_count = 10'(live_regions);
        o.overflow     = ovf_sticky[0];
        return o;
    endfunction

    // one command transaction; valid stays up, payload held, until accepted
    task automatic send_cmd(in_t c);
        if (!quiet() && $urandom_range(99) < 6) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= c;
        @(negedge aclk);
        while (!s_ready) @(negedge aclk);
        @(posedge aclk);
        pending_results.push_back(region_result(c));
    endtask

    // sender pause until every result is back
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    function automatic in_t mk_cmd(func_t f, int x, int y, int w, int h, int id, int idx);
        in_t c;
        c.func         = f;
        c.win_x        = 11'(x);
        c.win_y        = 11'(y);
        c.win_w        = 11'(w);
        c.win_h        = 11'(h);
        c.window_id    = 8'(id);
        c.region_index = 9'(idx);
        return c;
    endfunction

    function automatic in_t rnd_fields(func_t f);
        in_t c;
        c      = in_t'(63'({$urandom, $urandom}));
        c.func = f;
        return c;
    endfunction

    // receiver: random idling, quiet stretches and one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (3000) @(posedge aclk);
                hold_req = 0;
            end
            m_ready <= quiet() ? 1'b1 : ($urandom_range(99) >= 6);
        end
    end

    // result checker: m_valid and m_ready are stable here, transaction lands at next edge
    always @(negedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result %h", $realtime, m_data);
                error_cnt++;
            end else begin
                want = pending_results.pop_front();
                if (m_data.reg_x != want.reg_x) begin
                    $display("%0t reg_x exp %0d got %0d", $realtime, want.reg_x, m_data.reg_x);
                    error_cnt++;
                end
                if (m_data.reg_y != want.reg_y) begin
                    $display("%0t reg_y exp %0d got %0d", $realtime, want.reg_y, m_data.reg_y);
                    error_cnt++;
                end
                if (m_data.reg_w != want.reg_w) begin
                    $display("%0t reg_w exp %0d got %0d", $realtime, want.reg_w, m_data.reg_w);
                    error_cnt++;
                end
                if (m_data.reg_h != want.reg_h) begin
                    $display("%0t reg_h exp %0d got %0d", $realtime, want.reg_h, m_data.reg_h);
                    error_cnt++;
                end
                if (m_data.reg_owner != want.reg_owner) begin
                    $display("%0t reg_owner exp %0d got %0d", $realtime, want.reg_owner,
                             m_data.reg_owner);
                    error_cnt++;
                end
                if (m_data.region_count != want.region_count) begin
                    $display("%0t region_count exp %0d got %0d", $realtime,
                             want.region_count, m_data.region_count);
                    error_cnt++;
                end
                if (m_data.index_valid !== want.index_valid) begin
                    $display("%0t index_valid exp %0b got %0b", $realtime,
                             want.index_valid, m_data.index_valid);
                    error_cnt++;
                end
                if (m_data.overflow !== want.overflow) begin
                    $display("%0t overflow exp %0b got %0b", $realtime, want.overflow,
                             m_data.overflow);
                    error_cnt++;
                end
            end
        end
    end

    // empty table, no-op and the split shapes
    task automatic test_directed();
        send_cmd(mk_cmd(FUNC_CLEAR, 0, 0, 0, 0, 0, 0));
        send_cmd(mk_cmd(FUNC_READ, 0, 0, 0, 0, 0, 0));
        send_cmd(mk_cmd(FUNC_READ, 0, 0, 0, 0, 0, 511));
        send_cmd(rnd_fields(FUNC_NOP));
        send_cmd(mk_cmd(FUNC_NOP, 2047, 2047, 2047, 2047, 255, 511));
        // full screen, then a window in the middle: four pieces
        send_cmd(mk_cmd(FUNC_ADD, 0, 0, 2047, 2047, 255, 0));
        send_cmd(mk_cmd(FUNC_ADD, 100, 100, 200, 200, 1, 0));
        for (int i = 0; i < 6; i++) send_cmd(mk_cmd(FUNC_READ, 0, 0, 0, 0, 0, i));
        // touching the first window only at its edge: it survives untouched
        send_cmd(mk_cmd(FUNC_ADD, 300, 100, 50, 200, 2, 0));
        // fully covering the first window: it is removed
        send_cmd(mk_cmd(FUNC_ADD, 90, 90, 220, 220, 3, 0));
        // zero size and the far corner with the widest extent
        send_cmd(mk_cmd(FUNC_ADD, 500, 500, 0, 0, 4, 0));
        send_cmd(mk_cmd(FUNC_ADD, 2047, 2047, 2047, 2047, 0, 0));
        send_cmd(mk_cmd(FUNC_ADD, 0, 1000, 2047, 10, 170, 0));
        for (int i = 0; i < 4; i++) send_cmd(mk_cmd(FUNC_READ, 0, 0, 0, 0, 0, i));
        send_cmd(mk_cmd(FUNC_READ, 0, 0, 0, 0, 0, 500));
        drain();
    endtask

    // fill the table past capacity, then check the sticky flag and its clear
    task automatic test_overflow();
        int n;
        n = 0;
        send_cmd(mk_cmd(FUNC_CLEAR, 0, 0, 0, 0, 0, 0));
        send_cmd(mk_cmd(FUNC_ADD, 0, 0, 2047, 2047, 85, 0));
        while ((live_regions < NREG || ovf_sticky == 0) && n < 400) begin
            send_cmd(mk_cmd(FUNC_ADD, $urandom_range(2000), $urandom_range(2000),
                            $urandom_range(1, 40), $urandom_range(1, 40),
                            $urandom_range(255), 0));
            n++;
        end
        // overlaps nothing while full: the last survivor is dropped
        send_cmd(mk_cmd(FUNC_ADD, 2047, 2047, 0, 0, 7, 0));
        send_cmd(mk_cmd(FUNC_READ, 0, 0, 0, 0, 0, 511));
        send_cmd(mk_cmd(FUNC_READ, 0, 0, 0, 0, 0, 0));
        send_cmd(mk_cmd(FUNC_READ, 0, 0, 0, 0, 0, $urandom_range(511)));
        send_cmd(mk_cmd(FUNC_CLEAR, 0, 0, 0, 0, 0, 0));
        send_cmd(mk_cmd(FUNC_READ, 0, 0, 0, 0, 0, 0));
        drain();
    endtask

    // long receiver hold-off while commands keep coming
    task automatic test_backpressure();
        hold_req = 1;
        send_cmd(mk_cmd(FUNC_ADD, 10, 10, 500, 500, 9, 0));
        for (int i = 0; i < 8; i++) send_cmd(mk_cmd(FUNC_READ, 0, 0, 0, 0, 0, i));
        drain();
    endtask

    // random mix, mostly adds and reads on a small table
    task automatic test_random();
        in_t c;
        int  r;
        for (int n = 0; n < 400; n++) begin
            r = $urandom_range(99);
            if (live_regions > 60 || r < 4) begin
                c = rnd_fields(FUNC_CLEAR);
            end else if (r < 7) begin
                c = rnd_fields(FUNC_NOP);
            end else if (r < 50) begin
                c = rnd_fields(FUNC_ADD);
                if ($urandom_range(99) < 80) begin
                    c.win_x = 11'($urandom_range(255));
                    c.win_y = 11'($urandom_range(255));
                    c.win_w = 11'($urandom_range(120));
                    c.win_h = 11'($urandom_range(120));
                end
            end else begin
                c = rnd_fields(FUNC_READ);
                if ($urandom_range(99) < 85) begin
                    c.region_index = 9'($urandom_range(live_regions + 2));
                end
            end
            send_cmd(c);
            if (n == 200) drain();
        end
        drain();
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_backpressure();
        test_overflow();
        test_random();
        repeat (50) @(posedge aclk);
        if (error_cnt == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #200ms;
        $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
design/worsp_pkg.sv
design/worsp_ram.sv
design/worsp_split.sv
design/window_occlusion_region_splitter_core.sv
bench/tb_window_occlusion_region_splitter_core.sv
